// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the permutation unranking block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication property on the rising edge of clk, off while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds on the rising edge of clk, off while in reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: hw/rtl/kpu_pkg.sv
// Package with the types, widths and factorial table of the permutation unranking block.
package kpu_pkg;

  localparam int LEN_W  = 4;
  localparam int RANK_W = 29;
  localparam int ELEM_W = 4;
  localparam int FACT_W = RANK_W + 1;

  // Largest length that the field width can carry.
  localparam int LEN_MAX = (1 << LEN_W) - 1;

  // Stands for any factorial that is larger than every possible rank.
  localparam logic [FACT_W-1:0] FACT_SAT = FACT_W'(1) << RANK_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic init;
    logic shift;
  } pool_ctrl_t;

  // Factorial of m, saturated above the rank range.
  function automatic logic [FACT_W-1:0] fact_sat(input logic [LEN_W-1:0] m);
    logic [FACT_W-1:0] f;
    case (m) inside
      4'd0, 4'd1: f = 30'd1;
      4'd2:       f = 30'd2;
      4'd3:       f = 30'd6;
      4'd4:       f = 30'd24;
      4'd5:       f = 30'd120;
      4'd6:       f = 30'd720;
      4'd7:       f = 30'd5040;
      4'd8:       f = 30'd40320;
      4'd9:       f = 30'd362880;
      4'd10:      f = 30'd3628800;
      4'd11:      f = 30'd39916800;
      4'd12:      f = 30'd479001600;
      default:    f = FACT_SAT;
    endcase
    return f;
  endfunction

endpackage

// File: hw/rtl/kpu_if.sv
// Valid/ready channel interfaces for request words and result words.
interface kpu_in_if;
  import kpu_pkg::*;

  logic              valid;
  logic              ready;
  logic [LEN_W-1:0]  length;
  logic [RANK_W-1:0] rank;

  modport source (output valid, output length, output rank, input ready);
  modport sink   (input valid, input length, input rank, output ready);
endinterface

interface kpu_out_if;
  import kpu_pkg::*;

  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element;
  logic              last;
  logic              bad_request;

  modport source (output valid, output element, output last, output bad_request, input ready);
  modport sink   (input valid, input element, input last, input bad_request, output ready);
endinterface

// File: hw/rtl/kth_permutation_unrank_core.sv
// Top level of the permutation unranking block (Lehmer code decoder).
//
// The in_ch channel takes one request word: a length n and a one-based rank k.
// The out_ch channel gives the k-th lexicographic permutation of 1..n as n
// result words, one element each, with last set on the n-th. A length outside
// 1..MAX_N or a rank outside 1..n! gives a single word with element 0, last
// and bad_request set.
// One subtract-and-compare unit finds each factorial-base digit by repeated
// subtraction of (m-1)!, one subtraction per cycle. Each position runs d
// subtractions, d being its digit, then presents its result word; a bad
// request goes straight to its error word. in_ch.ready is high only between
// requests.
// Each result word sits in an output register until out_ch.ready takes it;
// decoding waits meanwhile, so a stalled receiver only lengthens the run.
// Reset (synchronous, rst_n low) returns the sequencer to idle and drops
// out_ch.valid and in_ch.ready; no clearing pass is needed.
`include "assert_macros.svh"

module kth_permutation_unrank_core #(
  parameter int MAX_N = 12
) (
  input logic     clk,
  input logic     rst_n,
  kpu_in_if.sink  in_ch,
  kpu_out_if.source out_ch
);
  import kpu_pkg::*;

  localparam int POOL_D = (MAX_N > LEN_MAX) ? LEN_MAX : MAX_N;
  localparam int IDX_W  = (POOL_D > 1) ? $clog2(POOL_D) : 1;
  localparam logic [LEN_W:0] MAXN_V = (LEN_W + 1)'(MAX_N);

  state_t            state_r, state_nxt;
  logic [RANK_W-1:0] r_r, r_nxt;
  logic [FACT_W-1:0] f_r, f_nxt;
  logic [LEN_W-1:0]  m_r, m_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [ELEM_W-1:0] elem_r, elem_nxt;
  logic              last_r, last_nxt;
  logic              bad_r, bad_nxt;

  logic              in_acc;
  logic              req_bad;
  logic              sub_ok;
  logic              final_pos;
  logic [FACT_W-1:0] diff;
  logic [ELEM_W-1:0] pool_val;
  pool_ctrl_t        pool_ctrl;

  assign in_acc = in_ch.valid && in_ch.ready;

  // Range check of the request word.
  assign req_bad = (in_ch.length == '0) || ({1'b0, in_ch.length} > MAXN_V) ||
                   (in_ch.rank == '0) || ({1'b0, in_ch.rank} > fact_sat(in_ch.length));

  // Shared subtract-and-compare unit: one step of the digit division.
  assign diff      = {1'b0, r_r} - f_r;
  assign final_pos = (m_r == LEN_W'(1));
  assign sub_ok    = ({1'b0, r_r} >= f_r) && (LEN_W'(pos_r) < (m_r - LEN_W'(1)));

  kpu_pool #(
    .DEPTH (POOL_D),
    .IDX_W (IDX_W)
  ) u_pool (
    .clk   (clk),
    .ctrl  (pool_ctrl),
    .pos   (pos_r),
    .value (pool_val)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = req_bad ? S_OUT : S_DIV;
        end
      end
      S_DIV: begin
        if (final_pos || !sub_ok) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = last_r ? S_IDLE : S_DIV;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake and pool controls of the sequencer.
  always_comb begin
    in_ch.ready     = 1'b0;
    out_ch.valid    = 1'b0;
    pool_ctrl.init  = 1'b0;
    pool_ctrl.shift = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready    = rst_n;
        pool_ctrl.init = in_acc;
      end
      S_DIV: begin
        pool_ctrl.shift = !final_pos && !sub_ok;
      end
      S_OUT: begin
        out_ch.valid = 1'b1;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // Datapath: remainder, divisor, digit count and result register.
  always_comb begin
    r_nxt    = r_r;
    f_nxt    = f_r;
    m_nxt    = m_r;
    pos_nxt  = pos_r;
    elem_nxt = elem_r;
    last_nxt = last_r;
    bad_nxt  = bad_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          r_nxt    = in_ch.rank - RANK_W'(1);
          f_nxt    = fact_sat(in_ch.length - LEN_W'(1));
          m_nxt    = in_ch.length;
          pos_nxt  = '0;
          elem_nxt = '0;
          last_nxt = req_bad;
          bad_nxt  = req_bad;
        end
      end
      S_DIV: begin
        if (final_pos) begin
          // The one value left closes the run.
          elem_nxt = pool_val;
          last_nxt = 1'b1;
        end else if (sub_ok) begin
          r_nxt   = diff[RANK_W-1:0];
          pos_nxt = pos_r + IDX_W'(1);
        end else begin
          // Digit found: emit the value and move to the next position.
          elem_nxt = pool_val;
          last_nxt = 1'b0;
          m_nxt    = m_r - LEN_W'(1);
          f_nxt    = fact_sat(m_r - LEN_W'(2));
          pos_nxt  = '0;
        end
      end
      default: begin
        r_nxt = r_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r    <= r_nxt;
    f_r    <= f_nxt;
    m_r    <= m_nxt;
    pos_r  <= pos_nxt;
    elem_r <= elem_nxt;
    last_r <= last_nxt;
    bad_r  <= bad_nxt;
  end

  assign out_ch.element     = elem_r;
  assign out_ch.last        = last_r;
  assign out_ch.bad_request = bad_r;

  // A request is taken only after the last word of the previous run has gone.
  `ASSERT_NEVER(a_no_overlap, in_ch.ready && out_ch.valid, "request taken during a run")
  // An error word is a lone, final word with a zero element.
  `ASSERT_NEVER(a_bad_last, out_ch.valid && bad_r && !(last_r && elem_r == '0), "bad word")
  // The digit never points past the remaining values.
  `ASSERT_CLK(a_pos_range, state_r == S_DIV |-> LEN_W'(pos_r) < m_r, "digit out of range")
  // A good run never emits a zero element.
  `ASSERT_NEVER(a_elem_nonzero, out_ch.valid && !bad_r && elem_r == '0, "zero element")

endmodule

// File: hw/rtl/kpu_pool.sv
// Ordered list of unused values with a read port and a remove-and-close-gap shift.
module kpu_pool #(
  parameter int DEPTH = 12,
  parameter int IDX_W = 4
) (
  input  logic                      clk,
  input  kpu_pkg::pool_ctrl_t       ctrl,
  input  logic [IDX_W-1:0]          pos,
  output logic [kpu_pkg::ELEM_W-1:0] value
);
  import kpu_pkg::*;

  logic [ELEM_W-1:0] pool_r   [DEPTH];
  logic [ELEM_W-1:0] pool_nxt [DEPTH];

  // Load 1..DEPTH on a new request, or remove the entry at pos and close the gap.
  always_comb begin
    pool_nxt = pool_r;
    if (ctrl.init) begin
      for (int j = 0; j < DEPTH; j++) begin
        pool_nxt[j] = ELEM_W'(j + 1);
      end
    end else if (ctrl.shift) begin
      for (int j = 0; j < DEPTH - 1; j++) begin
        if (IDX_W'(j) >= pos) begin
          pool_nxt[j] = pool_r[j + 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pool_r <= pool_nxt;
  end

  assign value = pool_r[pos];

endmodule
